@@ design/ppm_p6_stream_parser_core_defines.svh @@
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser_core_defines
// Assertion macros shared by the PPM P6 parser checker.
// ----------------------------------------------------------------------------
`ifndef PPM_P6_STREAM_PARSER_CORE_DEFINES_SVH
`define PPM_P6_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define PPM_P6_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define PPM_P6_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// next-cycle implication, checked during reset as well
`define PPM_P6_ASSERT_ALWAYS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/ppm_p6_pkg.sv @@
// ----------------------------------------------------------------------------
// ppm_p6_pkg
// Types and constants shared by the PPM P6 stream parser.
// ----------------------------------------------------------------------------
package ppm_p6_pkg;

   localparam logic [16:0] MAX_DIM = 17'd32768;
   localparam logic [16:0] ACC_MAX = 17'h1ffff;
   localparam logic [16:0] MAXVAL_8BIT = 17'h000ff;

   localparam logic [7:0] CHAR_P = 8'h50;
   localparam logic [7:0] CHAR_6 = 8'h36;
   localparam logic [7:0] CHAR_0 = 8'h30;
   localparam logic [7:0] CHAR_9 = 8'h39;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_LF = 8'h0a;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_SIG = 3'd1;
   localparam logic [2:0] ST_SEP = 3'd2;
   localparam logic [2:0] ST_FORMAT = 3'd3;
   localparam logic [2:0] ST_WIDE = 3'd4;
   localparam logic [2:0] ST_HIGH = 3'd5;
   localparam logic [2:0] ST_DEPTH = 3'd6;

   typedef struct packed {
      logic [7:0] data_byte;
      logic end_of_file;
   } req_type;

   typedef struct packed {
      logic [23:0] pixel_rgb;
      logic is_pixel;
      logic is_final;
      logic [2:0] status;
      logic [15:0] image_width;
      logic [15:0] image_height;
   } rsp_type;

   typedef struct packed {
      logic valid;
      rsp_type data;
   } result_type;

endpackage

@@ design/ppm_p6_in_stage.sv @@
// ----------------------------------------------------------------------------
// ppm_p6_in_stage
// Input register that holds one request until the parser consumes it.
// ----------------------------------------------------------------------------
module ppm_p6_in_stage (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ppm_p6_pkg::req_type req,
   input  logic advance,
   output logic hold_valid,
   output ppm_p6_pkg::req_type hold_data
);

   logic valid_ff;
   logic valid_in;
   ppm_p6_pkg::req_type data_ff;
   logic load;

   assign req_ready = !valid_ff || advance;
   assign load = req_valid && req_ready;
   assign valid_in = load || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= req;
      end
   end

   assign hold_valid = valid_ff;
   assign hold_data = data_ff;

endmodule

@@ design/ppm_p6_parser.sv @@
// ----------------------------------------------------------------------------
// ppm_p6_parser
// Header and pixel state machine; one byte per step, at most one result.
// ----------------------------------------------------------------------------
module ppm_p6_parser (
   input  logic clock,
   input  logic reset,
   input  logic step_en,
   input  ppm_p6_pkg::req_type req,
   output ppm_p6_pkg::result_type result
);

   typedef enum logic [3:0] {
      PH_SIG_P  = 4'd0,
      PH_SIG_6  = 4'd1,
      PH_SEP    = 4'd2,
      PH_WIDTH  = 4'd3,
      PH_HEIGHT = 4'd4,
      PH_MAXVAL = 4'd5,
      PH_PIXELS = 4'd6,
      PH_END    = 4'd7,
      PH_DRAIN  = 4'd8
   } phase_type;

   phase_type phase_ff, phase_in;
   logic [16:0] acc_ff, acc_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [1:0] bip_ff, bip_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] row_ff, row_in;
   logic [15:0] partial_ff, partial_in;

   logic [7:0] b;
   logic eof;
   logic is_space;
   logic is_digit;
   logic [20:0] prod;
   logic [16:0] col_next;
   logic [16:0] row_next;
   logic [2:0] err;
   logic have_pixel;
   logic [23:0] rgb;
   logic clear;

   assign b = req.data_byte;
   assign eof = req.end_of_file;
   assign is_space = (b == ppm_p6_pkg::CHAR_SPACE) || (b == ppm_p6_pkg::CHAR_TAB) ||
                     (b == ppm_p6_pkg::CHAR_CR) || (b == ppm_p6_pkg::CHAR_LF);
   assign is_digit = (b >= ppm_p6_pkg::CHAR_0) && (b <= ppm_p6_pkg::CHAR_9);
   // acc * 10 + digit
   assign prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} +
                 {13'd0, b - ppm_p6_pkg::CHAR_0};
   assign col_next = {1'b0, col_ff} + 17'd1;
   assign row_next = {1'b0, row_ff} + 17'd1;

   always_comb begin
      phase_in = phase_ff;
      acc_in = acc_ff;
      width_in = width_ff;
      height_in = height_ff;
      bip_in = bip_ff;
      col_in = col_ff;
      row_in = row_ff;
      partial_in = partial_ff;
      err = ppm_p6_pkg::ST_OK;
      have_pixel = 1'b0;
      rgb = '0;
      clear = 1'b0;
      result = '0;

      unique case (phase_ff) inside
         PH_SIG_P: begin
            if (b != ppm_p6_pkg::CHAR_P) err = ppm_p6_pkg::ST_SIG;
            else phase_in = PH_SIG_6;
         end
         PH_SIG_6: begin
            if (b != ppm_p6_pkg::CHAR_6) err = ppm_p6_pkg::ST_SIG;
            else phase_in = PH_SEP;
         end
         PH_SEP: begin
            if (!is_space) err = ppm_p6_pkg::ST_SEP;
            else phase_in = PH_WIDTH;
         end
         PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
            if (is_space) begin
               acc_in = '0;
               if (phase_ff == PH_WIDTH) begin
                  if (acc_ff == '0 || acc_ff > ppm_p6_pkg::MAX_DIM) begin
                     err = ppm_p6_pkg::ST_WIDE;
                  end else begin
                     width_in = acc_ff[15:0];
                     phase_in = PH_HEIGHT;
                  end
               end else if (phase_ff == PH_HEIGHT) begin
                  if (acc_ff == '0 || acc_ff > ppm_p6_pkg::MAX_DIM) begin
                     err = ppm_p6_pkg::ST_HIGH;
                  end else begin
                     height_in = acc_ff[15:0];
                     phase_in = PH_MAXVAL;
                  end
               end else begin
                  if (acc_ff != ppm_p6_pkg::MAXVAL_8BIT) err = ppm_p6_pkg::ST_DEPTH;
                  else phase_in = PH_PIXELS;
               end
            end else if (is_digit) begin
               acc_in = (prod > {4'd0, ppm_p6_pkg::ACC_MAX}) ? ppm_p6_pkg::ACC_MAX :
                        prod[16:0];
            end else begin
               err = ppm_p6_pkg::ST_FORMAT;
            end
         end
         PH_PIXELS: begin
            if (bip_ff < 2'd2) begin
               partial_in = {partial_ff[7:0], b};
               bip_in = bip_ff + 2'd1;
            end else begin
               rgb = {partial_ff, b};
               have_pixel = 1'b1;
               bip_in = '0;
               partial_in = '0;
               if (col_next >= {1'b0, width_ff}) begin
                  col_in = '0;
                  row_in = row_next[15:0];
                  if (row_next >= {1'b0, height_ff}) phase_in = PH_END;
               end else begin
                  col_in = col_next[15:0];
               end
            end
         end
         PH_END: begin
            err = ppm_p6_pkg::ST_FORMAT;
         end
         default: begin
            phase_in = PH_DRAIN;
         end
      endcase

      result.data.image_width = width_in;
      result.data.image_height = height_in;
      if (err != ppm_p6_pkg::ST_OK) begin
         result.valid = 1'b1;
         result.data.is_final = 1'b1;
         result.data.status = err;
         if (eof) clear = 1'b1;
         else phase_in = PH_DRAIN;
      end else if (phase_in == PH_DRAIN) begin
         clear = eof;
      end else if (eof) begin
         result.valid = 1'b1;
         result.data.pixel_rgb = rgb;
         result.data.is_pixel = have_pixel;
         result.data.is_final = 1'b1;
         result.data.status = (phase_in == PH_END) ? ppm_p6_pkg::ST_OK :
                              ppm_p6_pkg::ST_FORMAT;
         clear = 1'b1;
      end else if (have_pixel) begin
         result.valid = 1'b1;
         result.data.pixel_rgb = rgb;
         result.data.is_pixel = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step_en && clear)) begin
         phase_ff <= PH_SIG_P;
         acc_ff <= '0;
         width_ff <= '0;
         height_ff <= '0;
         bip_ff <= '0;
         col_ff <= '0;
         row_ff <= '0;
         partial_ff <= '0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff <= acc_in;
         width_ff <= width_in;
         height_ff <= height_in;
         bip_ff <= bip_in;
         col_ff <= col_in;
         row_ff <= row_in;
         partial_ff <= partial_in;
      end
   end

endmodule

@@ design/ppm_p6_out_stage.sv @@
// ----------------------------------------------------------------------------
// ppm_p6_out_stage
// Result register between the parser and the result channel.
// ----------------------------------------------------------------------------
module ppm_p6_out_stage (
   input  logic clock,
   input  logic reset,
   input  logic step_en,
   input  ppm_p6_pkg::result_type result,
   output logic can_take,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ppm_p6_pkg::rsp_type rsp
);

   logic valid_ff;
   logic valid_in;
   ppm_p6_pkg::rsp_type data_ff;
   logic load;

   assign can_take = !valid_ff || rsp_ready;
   assign load = step_en && result.valid;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= result.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp = data_ff;

endmodule

@@ design/ppm_p6_stream_parser_core.sv @@
// ----------------------------------------------------------------------------
// ppm_p6_stream_parser_core
// Binary PPM (P6) byte stream parser producing packed RGB pixels.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle and returns packed 24-bit pixels plus one
// final result per file with a status. A request passes an input register,
// one parse step and a result register, so a result is presented at the
// earliest from the clock edge after the one that takes its request; a new
// request is taken every cycle while the result register is empty or being
// drained, and the rate is set by the consumer taking results. After an error
// all bytes up to the end-of-file marker are dropped with no results, then
// parsing restarts at the signature.
module ppm_p6_stream_parser_core (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  ppm_p6_pkg::req_type req,
   output logic rsp_valid,
   input  logic rsp_ready,
   output ppm_p6_pkg::rsp_type rsp
);

   logic hold_valid;
   ppm_p6_pkg::req_type hold_data;
   logic can_take;
   logic step_en;
   ppm_p6_pkg::result_type result;

   assign step_en = hold_valid && can_take;

   ppm_p6_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req(req),
      .advance(step_en),
      .hold_valid(hold_valid),
      .hold_data(hold_data)
   );

   ppm_p6_parser u_parser (
      .clock(clock),
      .reset(reset),
      .step_en(step_en),
      .req(hold_data),
      .result(result)
   );

   ppm_p6_out_stage u_out_stage (
      .clock(clock),
      .reset(reset),
      .step_en(step_en),
      .result(result),
      .can_take(can_take),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp(rsp)
   );

endmodule

@@ design/ppm_p6_checker.sv @@
// ----------------------------------------------------------------------------
// ppm_p6_checker
// Port-level checks for the PPM P6 stream parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "ppm_p6_stream_parser_core_defines.svh"

module ppm_p6_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input ppm_p6_pkg::rsp_type rsp
);

   `PPM_P6_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result valid after reset")
   `PPM_P6_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled result changed")
   `PPM_P6_ASSERT_NOW(a_no_pixel_zero, rsp_valid && !rsp.is_pixel, rsp.pixel_rgb == '0, "pixel data without pixel")
   `PPM_P6_ASSERT_NOW(a_status_final, rsp_valid && !rsp.is_final, rsp.status == ppm_p6_pkg::ST_OK, "status on a non-final result")

endmodule

bind ppm_p6_stream_parser_core ppm_p6_checker u_checker (.*);

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PPM P6 stream parser core.
// ----------------------------------------------------------------------------
// Feeds whole files byte by byte: a few hand-written files first, then random
// images. Most images are well formed and the rest carry one flaw: a broken
// header byte, an odd width, height or maxval, a cut-off tail, or bytes past
// the last pixel. A parser model in the bench predicts every pixel and final
// status as each byte is taken. Results are checked field by field in order.
// Sender gaps and receiver stalls change from phase to phase. One long
// receiver hold-off makes the core fill up and stall its input.
// ----------------------------------------------------------------------------
module tb;
   import ppm_p6_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned LONG_HOLD = 150;
   localparam int unsigned DRAIN_LIMIT = 20000;
   localparam int unsigned PHASE_BYTES = 180;

   typedef enum logic [3:0] {
      S_WANT_P, S_WANT_6, S_WANT_SEP, S_WIDTH, S_HEIGHT, S_MAXVAL, S_PIXELS, S_DONE, S_DROP
   } hdr_state_type;

   typedef enum int unsigned {
      FLAW_NONE, FLAW_HEADER_BYTE, FLAW_TRUNCATE, FLAW_EXTRA, FLAW_WIDTH, FLAW_HEIGHT,
      FLAW_MAXVAL
   } flaw_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp;

   req_type byte_q[$];
   rsp_type expected_q[$];
   logic [7:0] file_buf[$];

   int unsigned bytes_offered = 0;
   int unsigned bytes_accepted = 0;
   int unsigned counted_bytes = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_requests = 0;
   int unsigned holds_taken = 0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned mismatch_count = 0;

   // parser model state
   hdr_state_type cur_state;
   logic [16:0] num_acc;
   logic [15:0] img_w;
   logic [15:0] img_h;
   logic [1:0] pix_byte;
   logic [15:0] col_cnt;
   logic [15:0] row_cnt;
   logic [15:0] partial_rgb;

   ppm_p6_stream_parser_core dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req(req),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp(rsp)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_parser();
      cur_state = S_WANT_P;
      num_acc = '0;
      img_w = '0;
      img_h = '0;
      pix_byte = '0;
      col_cnt = '0;
      row_cnt = '0;
      partial_rgb = '0;
   endfunction

   function automatic bit is_blank(logic [7:0] b);
      return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_LF;
   endfunction

   // one file byte through the parser; returns 1 when a result is due
   function automatic bit parse_byte(input req_type r, output rsp_type res);
      logic [2:0] err;
      bit got_pixel;
      logic [23:0] rgb;
      logic [16:0] num;
      logic [20:0] wide_num;
      err = ST_OK;
      got_pixel = 1'b0;
      rgb = '0;
      res = '0;
      case (cur_state)
         S_WANT_P: begin
            if (r.data_byte != CHAR_P) err = ST_SIG;
            else cur_state = S_WANT_6;
         end
         S_WANT_6: begin
            if (r.data_byte != CHAR_6) err = ST_SIG;
            else cur_state = S_WANT_SEP;
         end
         S_WANT_SEP: begin
            if (!is_blank(r.data_byte)) err = ST_SEP;
            else cur_state = S_WIDTH;
         end
         S_WIDTH, S_HEIGHT, S_MAXVAL: begin
            if (is_blank(r.data_byte)) begin
               num = num_acc;
               num_acc = '0;
               if (cur_state == S_WIDTH) begin
                  if (num == 0 || num > MAX_DIM) err = ST_WIDE;
                  else begin
                     img_w = num[15:0];
                     cur_state = S_HEIGHT;
                  end
               end else if (cur_state == S_HEIGHT) begin
                  if (num == 0 || num > MAX_DIM) err = ST_HIGH;
                  else begin
                     img_h = num[15:0];
                     cur_state = S_MAXVAL;
                  end
               end else begin
                  if (num != MAXVAL_8BIT) err = ST_DEPTH;
                  else cur_state = S_PIXELS;
               end
            end else if (r.data_byte >= CHAR_0 && r.data_byte <= CHAR_9) begin
               wide_num = 21'(num_acc) * 21'd10 + 21'(r.data_byte - CHAR_0);
               num_acc = (wide_num > 21'(ACC_MAX)) ? ACC_MAX : wide_num[16:0];
            end else begin
               err = ST_FORMAT;
            end
         end
         S_PIXELS: begin
            if (pix_byte < 2'd2) begin
               partial_rgb = {partial_rgb[7:0], r.data_byte};
               pix_byte = pix_byte + 2'd1;
            end else begin
               rgb = {partial_rgb, r.data_byte};
               got_pixel = 1'b1;
               pix_byte = '0;
               partial_rgb = '0;
               col_cnt = col_cnt + 16'd1;
               if (col_cnt >= img_w) begin
                  col_cnt = '0;
                  row_cnt = row_cnt + 16'd1;
                  if (row_cnt >= img_h) cur_state = S_DONE;
               end
            end
         end
         S_DONE: err = ST_FORMAT;
         default: cur_state = S_DROP;
      endcase

      res.image_width = img_w;
      res.image_height = img_h;
      if (err != ST_OK) begin
         res.is_final = 1'b1;
         res.status = err;
         if (r.end_of_file) clear_parser();
         else cur_state = S_DROP;
         return 1'b1;
      end
      if (cur_state == S_DROP) begin
         if (r.end_of_file) clear_parser();
         return 1'b0;
      end
      if (r.end_of_file) begin
         res.pixel_rgb = rgb;
         res.is_pixel = got_pixel;
         res.is_final = 1'b1;
         res.status = (cur_state == S_DONE) ? ST_OK : ST_FORMAT;
         clear_parser();
         return 1'b1;
      end
      if (got_pixel) begin
         res.pixel_rgb = rgb;
         res.is_pixel = 1'b1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      if (mismatch_count < 40)
         $display("[tb] %0t: %s got %0h want %0h", $time, what, got_v, want_v);
      mismatch_count++;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_q.size() == 0) begin
         report_mismatch("result with none pending", 32'(got.pixel_rgb), 32'd0);
      end else begin
         want = expected_q.pop_front();
         if (got.pixel_rgb !== want.pixel_rgb)
            report_mismatch("pixel_rgb", 32'(got.pixel_rgb), 32'(want.pixel_rgb));
         if (got.is_pixel !== want.is_pixel)
            report_mismatch("is_pixel", 32'(got.is_pixel), 32'(want.is_pixel));
         if (got.is_final !== want.is_final)
            report_mismatch("is_final", 32'(got.is_final), 32'(want.is_final));
         if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
         if (got.image_width !== want.image_width)
            report_mismatch("image_width", 32'(got.image_width), 32'(want.image_width));
         if (got.image_height !== want.image_height)
            report_mismatch("image_height", 32'(got.image_height), 32'(want.image_height));
      end
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (bytes_accepted == bytes_offered) begin
         if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req <= byte_q.pop_front();
            req_valid <= 1'b1;
            bytes_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with the long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (holds_taken != hold_requests) begin
         rsp_ready <= 1'b0;
         hold_left = LONG_HOLD;
         holds_taken++;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor
   always @(posedge clock) begin : monitor
      rsp_type next_res;
      if (reset) begin
         clear_parser();
      end else begin
         if (req_valid && req_ready) begin
            bytes_accepted++;
            if (parse_byte(req, next_res)) expected_q.push_back(next_res);
         end
         if (rsp_valid && rsp_ready) check_result(rsp);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[ppm_p6_stream_parser_core] ERROR");
         $finish;
      end
   end

   function automatic void add_blank();
      case ($urandom_range(3))
         0: file_buf.push_back(CHAR_SPACE);
         1: file_buf.push_back(CHAR_TAB);
         2: file_buf.push_back(CHAR_CR);
         default: file_buf.push_back(CHAR_LF);
      endcase
   endfunction

   function automatic void add_text(string s);
      for (int i = 0; i < s.len(); i++) file_buf.push_back(s[i]);
   endfunction

   function automatic string num_text(int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      if ($urandom_range(5) == 0) s = {"0", s};
      return s;
   endfunction

   function automatic string odd_number_text(bit for_maxval);
      string s;
      int unsigned n;
      case ($urandom_range(7))
         0: s = "";
         1: s = "0";
         2: s = for_maxval ? "254" : "32768";
         3: s = for_maxval ? "256" : "32769";
         4: s = for_maxval ? "511" : "65536";
         5: s = for_maxval ? "65791" : "131072";
         6: s = for_maxval ? "0255" : "12a";
         default: begin
            s = "";
            n = $urandom_range(6, 10);
            for (int i = 0; i < n; i++) s = {s, $sformatf("%0d", $urandom_range(9))};
         end
      endcase
      return s;
   endfunction

   // moves the assembled file into the request queue, marker on its last byte
   function automatic void ship_file();
      req_type r;
      foreach (file_buf[i]) begin
         r.data_byte = file_buf[i];
         r.end_of_file = (i == file_buf.size() - 1);
         byte_q.push_back(r);
      end
      file_buf.delete();
   endfunction

   task automatic queue_file(input bit clean, input int unsigned max_w, input int unsigned max_h);
      string wtxt, htxt, mtxt;
      int unsigned w, h, npix, header_len, cut;
      flaw_kind_type flaw;
      w = $urandom_range(1, max_w);
      h = $urandom_range(1, max_h);
      npix = w * h;
      wtxt = num_text(w);
      htxt = num_text(h);
      mtxt = ($urandom_range(4) == 0) ? "0255" : "255";
      flaw = clean ? FLAW_NONE : flaw_kind_type'($urandom_range(FLAW_HEADER_BYTE, FLAW_MAXVAL));
      case (flaw)
         FLAW_WIDTH: begin
            wtxt = odd_number_text(1'b0);
            npix = $urandom_range(0, 4);
         end
         FLAW_HEIGHT: begin
            htxt = odd_number_text(1'b0);
            npix = $urandom_range(0, 4);
         end
         FLAW_MAXVAL: mtxt = odd_number_text(1'b1);
         default: ;
      endcase
      file_buf.push_back(CHAR_P);
      file_buf.push_back(CHAR_6);
      add_blank();
      add_text(wtxt);
      add_blank();
      add_text(htxt);
      add_blank();
      add_text(mtxt);
      add_blank();
      header_len = file_buf.size();
      repeat (3 * npix) file_buf.push_back(8'($urandom_range(255)));
      case (flaw)
         FLAW_HEADER_BYTE: file_buf[$urandom_range(header_len - 1)] = 8'($urandom_range(255));
         FLAW_TRUNCATE: begin
            cut = $urandom_range(1, file_buf.size() - 1);
            while (file_buf.size() > cut) void'(file_buf.pop_back());
         end
         FLAW_EXTRA: repeat ($urandom_range(1, 3)) file_buf.push_back(8'($urandom_range(255)));
         default: ;
      endcase
      counted_bytes += file_buf.size();
      ship_file();
   endtask

   task automatic wait_sent();
      while (byte_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_phase(int unsigned idle_pct, int unsigned stall_pct, int unsigned quota);
      int unsigned goal;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      goal = counted_bytes + quota;
      while (counted_bytes < goal) begin
         queue_file($urandom_range(99) < 65, 4, 3);
         wait_sent();
      end
   endtask

   initial begin
      int unsigned wait_left;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pixel and marker on the same byte
      add_text("P6\n1 1\n255\n");
      file_buf.push_back(8'hff);
      file_buf.push_back(8'h00);
      file_buf.push_back(8'h80);
      ship_file();
      // bad signature on the marker byte
      add_text("Q");
      ship_file();
      // bad separator, then dropped bytes up to the marker
      add_text("P6xz");
      ship_file();
      // empty width
      add_text("P6  ");
      ship_file();
      counted_bytes += 23;
      wait_sent();

      run_phase(0, 0, PHASE_BYTES);
      run_phase(71, 0, PHASE_BYTES);
      run_phase(0, 71, PHASE_BYTES);
      run_phase(30, 30, PHASE_BYTES);

      // receiver holds off while the sender keeps pushing
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_requests++;
      repeat (3) queue_file(1'b1, 8, 6);
      wait_sent();

      while (bytes_accepted != bytes_offered) @(posedge clock);
      wait_left = DRAIN_LIMIT;
      while (expected_q.size() != 0 && wait_left != 0) begin
         @(posedge clock);
         wait_left--;
      end
      repeat (20) @(posedge clock);
      if (expected_q.size() != 0)
         report_mismatch("results never arrived", 32'(expected_q.size()), 32'd0);

      if (mismatch_count == 0) begin
         $display("[ppm_p6_stream_parser_core] OK");
      end else begin
         $display("[ppm_p6_stream_parser_core] ERROR");
      end
      $finish;
   end

endmodule

@@ ppm_p6_stream_parser_core.f @@
+incdir+design
design/ppm_p6_pkg.sv
design/ppm_p6_in_stage.sv
design/ppm_p6_parser.sv
design/ppm_p6_out_stage.sv
design/ppm_p6_stream_parser_core.sv
design/ppm_p6_checker.sv
verif/tb.sv
